// ===== design/midi_controller_turn_aggregator_unit_assert.svh =====
// assertion macros for the controller turn aggregator
// used by mcta_ctrl and mcta_datapath, no other dependencies
`ifndef MIDI_CONTROLLER_TURN_AGGREGATOR_UNIT_ASSERT_SVH
`define MIDI_CONTROLLER_TURN_AGGREGATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MCTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define MCTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MCTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/mcta_pkg.sv =====
// types, codes and constants shared by the controller turn aggregator
// no dependencies
`default_nettype none

package mcta_pkg;

	localparam int TRACKED_CONTROLLERS_DEF = 32;
	localparam int RESULT_LIMIT            = 32;
	localparam int RES_CNT_W               = $clog2(RESULT_LIMIT + 1);
	localparam int CFG_IDX_W               = 2;
	localparam int CFG_DATA_W              = 16;

	localparam logic [15:0] WINDOW_RESET      = 16'd250;
	localparam logic [7:0]  MIN_CHANGES_RESET = 8'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGES = 2'd1;

	// input commands and message kinds
	localparam logic       CMD_RECORD     = 1'b0;
	localparam logic       CMD_FLUSH      = 1'b1;
	localparam logic [1:0] MSG_NOTE_ON    = 2'd0;
	localparam logic [1:0] MSG_NOTE_OFF   = 2'd1;
	localparam logic [1:0] MSG_CONTROLLER = 2'd2;
	localparam logic [1:0] MSG_PROGRAM    = 2'd3;

	// result codes
	localparam logic       EK_SINGLE   = 1'b0;
	localparam logic       EK_PARAM    = 1'b1;
	localparam logic [1:0] SK_NOTE_ON  = 2'd0;
	localparam logic [1:0] SK_NOTE_OFF = 2'd1;
	localparam logic [1:0] SK_PROGRAM  = 2'd2;
	localparam logic [1:0] SK_UNKNOWN  = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  msg_kind;
		logic [4:0]  rec_channel;
		logic [6:0]  first_byte;
		logic [6:0]  second_byte;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [1:0]  single_kind;
		logic [4:0]  out_channel;
		logic [6:0]  number_out;
		logic [6:0]  end_or_value;
		logic [6:0]  start_value_out;
		logic [15:0] run_changes;
		logic [31:0] event_time_ms;
		logic [31:0] run_duration_ms;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [6:0]  last_value;
		logic [15:0] turn_cnt;
		logic [31:0] first_time;
		logic [31:0] last_time;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REC,
		ST_SCAN,
		ST_DRAIN
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic rec_eval;
		logic scan_eval;
		logic scan_read;
		logic drain;
	} dp_cmd_t;

	// datapath to controller, decoded from the live input item
	typedef struct packed {
		logic in_flush;
		logic in_tracked;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/mcta_ctrl.sv =====
// sequencing state machine of the controller turn aggregator
// depends on mcta_pkg and the assertion macro header
`default_nettype none
`include "midi_controller_turn_aggregator_unit_assert.svh"

module mcta_ctrl #(
	parameter int TRACKED_CONTROLLERS = mcta_pkg::TRACKED_CONTROLLERS_DEF,
	localparam int IW = (TRACKED_CONTROLLERS > 1) ? $clog2(TRACKED_CONTROLLERS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire mcta_pkg::dp_status_t   status,
	output logic                        busy,
	output mcta_pkg::dp_cmd_t           cmd,
	output logic [IW-1:0]               scan_idx
);

	localparam logic [IW-1:0] LAST_IDX = IW'(TRACKED_CONTROLLERS - 1);

	mcta_pkg::ctrl_state_t state_q, state_d;
	logic [IW-1:0]         idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcta_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			mcta_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					idx_d       = '0;
					if (status.in_flush) begin
						state_d = mcta_pkg::ST_SCAN;
					end else if (status.in_tracked) begin
						state_d = mcta_pkg::ST_REC;
					end
				end
			end
			mcta_pkg::ST_REC: begin
				cmd.rec_eval = 1'b1;
				state_d      = mcta_pkg::ST_IDLE;
			end
			mcta_pkg::ST_SCAN: begin
				cmd.scan_eval = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = mcta_pkg::ST_DRAIN;
				end else begin
					// fetch the next entry while this one is evaluated
					cmd.scan_read = 1'b1;
					idx_d         = idx_q + 1'b1;
				end
			end
			mcta_pkg::ST_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = mcta_pkg::ST_IDLE;
			end
			default: begin
				state_d = mcta_pkg::ST_IDLE;
			end
		endcase
	end

	assign scan_idx = idx_q;

	`MCTA_ASSERT_NXT(a_scan_ends_in_drain, clk, arst_n, (state_q == mcta_pkg::ST_SCAN) && (idx_q == LAST_IDX), state_q == mcta_pkg::ST_DRAIN)
	`MCTA_ASSERT_NXT(a_flush_starts_scan, clk, arst_n, start && !busy && status.in_flush, (state_q == mcta_pkg::ST_SCAN) && (idx_q == '0))
	`MCTA_ASSERT_NXT(a_rec_one_cycle, clk, arst_n, state_q == mcta_pkg::ST_REC, state_q == mcta_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== design/mcta_datapath.sv =====
// entry memory, run evaluation, configuration and result registers
// depends on mcta_pkg and the assertion macro header
`default_nettype none
`include "midi_controller_turn_aggregator_unit_assert.svh"

module mcta_datapath #(
	parameter int TRACKED_CONTROLLERS = mcta_pkg::TRACKED_CONTROLLERS_DEF,
	localparam int IW = (TRACKED_CONTROLLERS > 1) ? $clog2(TRACKED_CONTROLLERS) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mcta_pkg::in_item_t                item,
	input  wire mcta_pkg::dp_cmd_t                 cmd,
	input  wire logic [IW-1:0]                     scan_idx,
	output mcta_pkg::dp_status_t                   status,
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [mcta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mcta_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mcta_pkg::result_t                      result,
	output logic                                   strobe
);

	mcta_pkg::in_item_t item_q;
	logic [15:0]        window_q;
	logic [7:0]         min_q;
	logic [TRACKED_CONTROLLERS-1:0] active_q;

	mcta_pkg::entry_t mem [TRACKED_CONTROLLERS];
	mcta_pkg::entry_t rd_q;

	mcta_pkg::result_t result_q, pend_q;
	logic              strobe_q, pend_v_q;
	logic [mcta_pkg::RES_CNT_W-1:0] flush_cnt_q;

	// live decode of the offered item
	logic single_now;
	always_comb begin
		status.in_flush   = (item.cmd == mcta_pkg::CMD_FLUSH);
		status.in_tracked = (item.cmd == mcta_pkg::CMD_RECORD)
			&& (item.msg_kind == mcta_pkg::MSG_CONTROLLER)
			&& ({1'b0, item.first_byte} < 8'(TRACKED_CONTROLLERS));
		single_now = cmd.capture && !status.in_flush && !status.in_tracked;
	end

	// memory read and write addresses
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, ev_idx;
	always_comb begin
		rd_en = cmd.capture || cmd.scan_read;
		if (cmd.capture) begin
			rd_addr = status.in_flush ? '0 : item.first_byte[IW-1:0];
		end else begin
			rd_addr = scan_idx + 1'b1;
		end
		ev_idx = cmd.scan_eval ? scan_idx : item_q.first_byte[IW-1:0];
		wr_en  = cmd.rec_eval;
	end

	// evaluation of the entry just read
	logic             cur_active, stale, qualifies, rec_report, flush_hit, flush_rep;
	logic [31:0]      gap, dur;
	logic [15:0]      cnt_inc;
	mcta_pkg::entry_t wr_data;
	always_comb begin
		cur_active = active_q[ev_idx];
		gap        = item_q.now_ms - rd_q.last_time;
		dur        = rd_q.last_time - rd_q.first_time;
		stale      = gap >= {16'd0, window_q};
		qualifies  = rd_q.turn_cnt >= {8'd0, min_q};
		cnt_inc    = (rd_q.turn_cnt == 16'hFFFF) ? rd_q.turn_cnt
			: rd_q.turn_cnt + 16'd1;
		if (cur_active && !stale) begin
			wr_data = '{last_value: item_q.second_byte, turn_cnt: cnt_inc,
				first_time: rd_q.first_time, last_time: item_q.now_ms};
		end else begin
			wr_data = '{last_value: item_q.second_byte, turn_cnt: 16'd1,
				first_time: item_q.now_ms, last_time: item_q.now_ms};
		end
		rec_report = cur_active && stale && qualifies;
		flush_hit  = cur_active && stale;
		flush_rep  = flush_hit && qualifies
			&& (flush_cnt_q < mcta_pkg::RES_CNT_W'(mcta_pkg::RESULT_LIMIT));
	end

	// result forms
	logic [1:0]        sk;
	mcta_pkg::result_t single_res, rec_res, flush_res, drain_res;
	always_comb begin
		case (item.msg_kind)
			mcta_pkg::MSG_NOTE_ON:  sk = mcta_pkg::SK_NOTE_ON;
			mcta_pkg::MSG_NOTE_OFF: sk = mcta_pkg::SK_NOTE_OFF;
			mcta_pkg::MSG_PROGRAM:  sk = mcta_pkg::SK_PROGRAM;
			default:                sk = mcta_pkg::SK_UNKNOWN;
		endcase
		single_res = '{event_kind: mcta_pkg::EK_SINGLE, single_kind: sk,
			out_channel: item.rec_channel, number_out: item.first_byte,
			end_or_value: item.second_byte, start_value_out: 7'd0, run_changes: 16'd0,
			event_time_ms: item.now_ms, run_duration_ms: 32'd0, last_of_run: 1'b1};
		rec_res = '{event_kind: mcta_pkg::EK_PARAM, single_kind: mcta_pkg::SK_NOTE_ON,
			out_channel: item_q.rec_channel, number_out: item_q.first_byte,
			end_or_value: item_q.second_byte, start_value_out: rd_q.last_value,
			run_changes: rd_q.turn_cnt, event_time_ms: rd_q.first_time,
			run_duration_ms: dur, last_of_run: 1'b1};
		flush_res = '{event_kind: mcta_pkg::EK_PARAM, single_kind: mcta_pkg::SK_NOTE_ON,
			out_channel: 5'd0, number_out: 7'(scan_idx),
			end_or_value: rd_q.last_value, start_value_out: rd_q.last_value,
			run_changes: rd_q.turn_cnt, event_time_ms: rd_q.first_time,
			run_duration_ms: dur, last_of_run: 1'b0};
		// the held report is the final one of the flush
		drain_res             = pend_q;
		drain_res.last_of_run = 1'b1;
	end

	// strobe for the next cycle
	logic strobe_d;
	always_comb begin
		strobe_d = 1'b0;
		if (cmd.capture) begin
			strobe_d = single_now;
		end
		if (cmd.rec_eval) begin
			strobe_d = rec_report;
		end
		if (cmd.scan_eval && flush_rep) begin
			// the held report goes out, the new one waits for a successor
			strobe_d = pend_v_q;
		end
		if (cmd.drain) begin
			strobe_d = pend_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ev_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= mcta_pkg::WINDOW_RESET;
			min_q       <= mcta_pkg::MIN_CHANGES_RESET;
			active_q    <= '0;
			strobe_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			flush_cnt_q <= '0;
		end else begin
			strobe_q <= strobe_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mcta_pkg::CFG_TURN_WINDOW: window_q <= cfg_data[15:0];
					mcta_pkg::CFG_MIN_CHANGES: min_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				pend_v_q    <= 1'b0;
				flush_cnt_q <= '0;
			end
			if (cmd.rec_eval) begin
				active_q[ev_idx] <= 1'b1;
			end
			if (cmd.scan_eval) begin
				if (flush_hit) begin
					active_q[ev_idx] <= 1'b0;
				end
				if (flush_rep) begin
					pend_v_q    <= 1'b1;
					flush_cnt_q <= flush_cnt_q + 1'b1;
				end
			end
			if (cmd.drain) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (single_now) begin
			result_q <= single_res;
		end else if (cmd.rec_eval && rec_report) begin
			result_q <= rec_res;
		end else if (cmd.scan_eval && flush_rep) begin
			result_q <= pend_q;
			pend_q   <= flush_res;
		end else if (cmd.drain) begin
			result_q <= drain_res;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

	`MCTA_ASSERT_IMP(a_single_is_last, clk, arst_n,
		strobe_q && (result_q.event_kind == mcta_pkg::EK_SINGLE), result_q.last_of_run)
	`MCTA_ASSERT_IMP(a_flush_cnt_bound, clk, arst_n, 1'b1,
		flush_cnt_q <= mcta_pkg::RES_CNT_W'(mcta_pkg::RESULT_LIMIT))
	`MCTA_ASSERT_NXT(a_drain_empties, clk, arst_n, cmd.drain, !pend_v_q)

endmodule

`default_nettype wire

// ===== design/midi_controller_turn_aggregator_unit.sv =====
// a single event's result appears in the cycle after start; a tracked controller record is read
// into the entry register, then evaluated into the result register; a flush holds each report until
// the next one is found and sends the last from the drain state; throughput: 1 item per cycle for
// single events; busy is high through a record and through a flush scanning one entry a cycle
// reset: asynchronous, active low; clears run tracking and loads the register defaults
// the receiver cannot stall: each result is valid for the single cycle that strobe is high
`default_nettype none

module midi_controller_turn_aggregator_unit #(
	parameter int TRACKED_CONTROLLERS = mcta_pkg::TRACKED_CONTROLLERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire mcta_pkg::in_item_t                item,
	output mcta_pkg::result_t                      result,
	output logic                                   strobe,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mcta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mcta_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW = (TRACKED_CONTROLLERS > 1) ? $clog2(TRACKED_CONTROLLERS) : 1;

	mcta_pkg::dp_cmd_t    dp_cmd;
	mcta_pkg::dp_status_t dp_status;
	logic [IW-1:0]        scan_idx;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	mcta_ctrl #(
		.TRACKED_CONTROLLERS(TRACKED_CONTROLLERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.status   (dp_status),
		.busy     (busy),
		.cmd      (dp_cmd),
		.scan_idx (scan_idx)
	);

	mcta_datapath #(
		.TRACKED_CONTROLLERS(TRACKED_CONTROLLERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (dp_cmd),
		.scan_idx  (scan_idx),
		.status    (dp_status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for midi_controller_turn_aggregator_unit: directed table, then random traffic
// predicts every result in-bench from run tracking state and checks each strobe in order
// depends on mcta_pkg and the unit's rtl only
`default_nettype none

module tb;

	localparam int NCTRL          = mcta_pkg::TRACKED_CONTROLLERS_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int NDIR           = 23;
	localparam mcta_pkg::result_t NO_RESULT = '0;

	typedef struct packed {
		mcta_pkg::in_item_t stim;
		logic               typed;
		mcta_pkg::result_t  want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mcta_pkg::in_item_t item = '0;
	mcta_pkg::result_t result;
	logic strobe;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mcta_pkg::CFG_IDX_W-1:0] cfg_index = mcta_pkg::CFG_TURN_WINDOW;
	logic [mcta_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// in-bench copy of the run tracking state and registers
	logic [15:0] win_ms = mcta_pkg::WINDOW_RESET;
	logic [7:0]  min_chg = mcta_pkg::MIN_CHANGES_RESET;
	bit          trk_active [NCTRL];
	logic [6:0]  trk_value [NCTRL];
	logic [15:0] trk_count [NCTRL];
	logic [31:0] trk_first [NCTRL];
	logic [31:0] trk_last [NCTRL];

	mcta_pkg::result_t pending_events [$];
	logic [31:0] clock_ms = 32'h0000_1000;
	int n_fail = 0;
	int quiet_cycles = 0;

	// single kind reads zero (note on) in a parameter change
	dir_row_t directed_rows [NDIR] = '{
		'{'{mcta_pkg::CMD_FLUSH, mcta_pkg::MSG_NOTE_ON, 5'd0, 7'd0, 7'd0, 32'd0}, 1'b0,
			NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_NOTE_ON, 5'd1, 7'd0, 7'd0, 32'd0}, 1'b1,
			'{mcta_pkg::EK_SINGLE, mcta_pkg::SK_NOTE_ON, 5'd1, 7'd0, 7'd0, 7'd0, 16'd0,
			32'd0, 32'd0, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_NOTE_OFF, 5'd16, 7'd127, 7'd127,
			32'hFFFF_FFFF}, 1'b1,
			'{mcta_pkg::EK_SINGLE, mcta_pkg::SK_NOTE_OFF, 5'd16, 7'd127, 7'd127, 7'd0, 16'd0,
			32'hFFFF_FFFF, 32'd0, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_PROGRAM, 5'd31, 7'd127, 7'd0, 32'd12345}, 1'b1,
			'{mcta_pkg::EK_SINGLE, mcta_pkg::SK_PROGRAM, 5'd31, 7'd127, 7'd0, 7'd0, 16'd0,
			32'd12345, 32'd0, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd0, 7'd127, 7'd64, 32'd500}, 1'b1,
			'{mcta_pkg::EK_SINGLE, mcta_pkg::SK_UNKNOWN, 5'd0, 7'd127, 7'd64, 7'd0, 16'd0,
			32'd500, 32'd0, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd2, 7'd32, 7'd1, 32'd501}, 1'b1,
			'{mcta_pkg::EK_SINGLE, mcta_pkg::SK_UNKNOWN, 5'd2, 7'd32, 7'd1, 7'd0, 16'd0,
			32'd501, 32'd0, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd3, 7'd5, 7'd10, 32'd1000}, 1'b0,
			NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd3, 7'd5, 7'd20, 32'd1010}, 1'b0,
			NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd3, 7'd5, 7'd30, 32'd1020}, 1'b0,
			NO_RESULT},
		// gap equal to the window closes the run
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd3, 7'd5, 7'd40, 32'd1270}, 1'b1,
			'{mcta_pkg::EK_PARAM, mcta_pkg::SK_NOTE_ON, 5'd3, 7'd5, 7'd40, 7'd30, 16'd3,
			32'd1000, 32'd20, 1'b1}},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd4, 7'd31, 7'd127, 32'd1300},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd4, 7'd31, 7'd0, 32'd1549},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd4, 7'd31, 7'd7, 32'd1798},
			1'b0, NO_RESULT},
		// flush with junk fields: reports controller 31, drops the short run on 5
		'{'{mcta_pkg::CMD_FLUSH, mcta_pkg::MSG_PROGRAM, 5'd31, 7'd127, 7'd127, 32'd2048}, 1'b1,
			'{mcta_pkg::EK_PARAM, mcta_pkg::SK_NOTE_ON, 5'd0, 7'd31, 7'd7, 7'd7, 16'd3,
			32'd1300, 32'd498, 1'b1}},
		// run across the 32 bit time wrap
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd16, 7'd0, 7'd1, 32'hFFFF_FF00},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd16, 7'd0, 7'd2, 32'hFFFF_FFF0},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd16, 7'd0, 7'd3, 32'h0000_0010},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd16, 7'd0, 7'd4, 32'h0000_0200},
			1'b1,
			'{mcta_pkg::EK_PARAM, mcta_pkg::SK_NOTE_ON, 5'd16, 7'd0, 7'd4, 7'd3, 16'd3,
			32'hFFFF_FF00, 32'h0000_0110, 1'b1}},
		'{'{mcta_pkg::CMD_FLUSH, mcta_pkg::MSG_NOTE_ON, 5'd0, 7'd0, 7'd0, 32'h0000_0200}, 1'b0,
			NO_RESULT},
		// staleness boundary on a flush: one short of the window, then exactly the window
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd1, 7'd1, 7'd127, 32'h0000_0300},
			1'b0, NO_RESULT},
		'{'{mcta_pkg::CMD_FLUSH, mcta_pkg::MSG_NOTE_ON, 5'd0, 7'd0, 7'd0, 32'h0000_03F9}, 1'b0,
			NO_RESULT},
		'{'{mcta_pkg::CMD_FLUSH, mcta_pkg::MSG_NOTE_ON, 5'd0, 7'd0, 7'd0, 32'h0000_03FA}, 1'b0,
			NO_RESULT},
		'{'{mcta_pkg::CMD_RECORD, mcta_pkg::MSG_CONTROLLER, 5'd1, 7'd1, 7'd5, 32'h0000_03FB},
			1'b0, NO_RESULT}
	};

	midi_controller_turn_aggregator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.result    (result),
		.strobe    (strobe),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void open_run(int idx, logic [6:0] val, logic [31:0] now);
		trk_active[idx] = 1'b1;
		trk_value[idx] = val;
		trk_count[idx] = 16'd1;
		trk_first[idx] = now;
		trk_last[idx] = now;
	endfunction

	// works out the results of one accepted item and updates the run tracking state
	function automatic void aggregate_item(mcta_pkg::in_item_t it);
		mcta_pkg::result_t found [$];
		mcta_pkg::result_t r;
		logic [31:0] gap;
		int idx;
		r = '0;
		if (it.cmd == mcta_pkg::CMD_FLUSH) begin
			for (int i = 0; i < NCTRL; i++) begin
				gap = it.now_ms - trk_last[i];
				if (trk_active[i] && gap >= {16'd0, win_ms}) begin
					if (trk_count[i] >= {8'd0, min_chg}
						&& found.size() < mcta_pkg::RESULT_LIMIT) begin
						r = '0;
						r.event_kind = mcta_pkg::EK_PARAM;
						r.out_channel = 5'd0;
						r.number_out = 7'(i);
						r.end_or_value = trk_value[i];
						r.start_value_out = trk_value[i];
						r.run_changes = trk_count[i];
						r.event_time_ms = trk_first[i];
						r.run_duration_ms = trk_last[i] - trk_first[i];
						found.push_back(r);
					end
					trk_active[i] = 1'b0;
					trk_value[i] = '0;
					trk_count[i] = '0;
					trk_first[i] = '0;
					trk_last[i] = '0;
				end
			end
		end else if (it.msg_kind == mcta_pkg::MSG_CONTROLLER && it.first_byte < NCTRL) begin
			idx = int'(it.first_byte);
			gap = it.now_ms - trk_last[idx];
			if (!trk_active[idx]) begin
				open_run(idx, it.second_byte, it.now_ms);
			end else if (gap < {16'd0, win_ms}) begin
				trk_value[idx] = it.second_byte;
				if (trk_count[idx] != 16'hFFFF) begin
					trk_count[idx] = trk_count[idx] + 16'd1;
				end
				trk_last[idx] = it.now_ms;
			end else begin
				if (trk_count[idx] >= {8'd0, min_chg}) begin
					r.event_kind = mcta_pkg::EK_PARAM;
					r.out_channel = it.rec_channel;
					r.number_out = it.first_byte;
					r.end_or_value = it.second_byte;
					r.start_value_out = trk_value[idx];
					r.run_changes = trk_count[idx];
					r.event_time_ms = trk_first[idx];
					r.run_duration_ms = trk_last[idx] - trk_first[idx];
					found.push_back(r);
				end
				open_run(idx, it.second_byte, it.now_ms);
			end
		end else begin
			r.event_kind = mcta_pkg::EK_SINGLE;
			case (it.msg_kind)
				mcta_pkg::MSG_NOTE_ON: r.single_kind = mcta_pkg::SK_NOTE_ON;
				mcta_pkg::MSG_NOTE_OFF: r.single_kind = mcta_pkg::SK_NOTE_OFF;
				mcta_pkg::MSG_PROGRAM: r.single_kind = mcta_pkg::SK_PROGRAM;
				default: r.single_kind = mcta_pkg::SK_UNKNOWN;
			endcase
			r.out_channel = it.rec_channel;
			r.number_out = it.first_byte;
			r.end_or_value = it.second_byte;
			r.event_time_ms = it.now_ms;
			found.push_back(r);
		end
		for (int k = 0; k < found.size(); k++) begin
			r = found[k];
			r.last_of_run = (k == found.size() - 1);
			pending_events.push_back(r);
		end
	endfunction

	function automatic mcta_pkg::in_item_t next_random_item();
		mcta_pkg::in_item_t it;
		logic [31:0] step;
		int sel;
		sel = int'($urandom_range(0, 99));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: step = $urandom_range(0, int'(win_ms) / 2);
			7, 8: step = {16'd0, win_ms} - 32'd1 + $urandom_range(0, 2);
			default: step = $urandom();
		endcase
		clock_ms = clock_ms + step;
		it.cmd = mcta_pkg::CMD_RECORD;
		it.msg_kind = 2'($urandom_range(0, 3));
		it.rec_channel = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(1, 16));
		it.first_byte = 7'($urandom_range(0, 127));
		it.second_byte = 7'($urandom_range(0, 127));
		it.now_ms = clock_ms;
		if (sel < 55) begin
			// mostly a few hot knobs so runs build up
			it.msg_kind = mcta_pkg::MSG_CONTROLLER;
			it.first_byte = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 3))
				: 7'($urandom_range(0, NCTRL - 1));
		end else if (sel < 70) begin
			it.cmd = mcta_pkg::CMD_FLUSH;
		end
		return it;
	endfunction

	task automatic send_item(mcta_pkg::in_item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and let every expected result arrive, plus a full scan's worth of cycles
	task automatic settle();
		start <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (NCTRL + 8) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] window, logic [7:0] min_changes);
		cfg_valid <= 1'b1;
		cfg_index <= mcta_pkg::CFG_TURN_WINDOW;
		cfg_data <= window;
		do @(posedge clk); while (!cfg_ready);
		win_ms = window;
		cfg_index <= mcta_pkg::CFG_MIN_CHANGES;
		cfg_data <= {8'd0, min_changes};
		do @(posedge clk); while (!cfg_ready);
		min_chg = min_changes;
		cfg_valid <= 1'b0;
	endtask

	// each cycle before an item idles with the given chance
	task automatic feed_random(int count, int idle_pct);
		mcta_pkg::in_item_t it;
		int gap;
		for (int n = 0; n < count; n++) begin
			it = next_random_item();
			gap = 0;
			while (int'($urandom_range(0, 99)) < idle_pct) gap++;
			send_item(it, gap);
			aggregate_item(it);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : result_check
		mcta_pkg::result_t want;
		if (arst_n && strobe) begin
			if (pending_events.size() == 0) begin
				$error("result with nothing expected");
				n_fail++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", 32'(want.event_kind), 32'(result.event_kind));
				check_field("single_kind", 32'(want.single_kind), 32'(result.single_kind));
				check_field("out_channel", 32'(want.out_channel), 32'(result.out_channel));
				check_field("number_out", 32'(want.number_out), 32'(result.number_out));
				check_field("end_or_value", 32'(want.end_or_value),
					32'(result.end_or_value));
				check_field("start_value_out", 32'(want.start_value_out),
					32'(result.start_value_out));
				check_field("run_changes", 32'(want.run_changes), 32'(result.run_changes));
				check_field("event_time_ms", want.event_time_ms, result.event_time_ms);
				check_field("run_duration_ms", want.run_duration_ms,
					result.run_duration_ms);
				check_field("last_of_run", 32'(want.last_of_run), 32'(result.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mcta_pkg::in_item_t it;
		int base;
		logic [31:0] t0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset register values
		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].stim, 0);
			base = pending_events.size();
			aggregate_item(directed_rows[k].stim);
			if (directed_rows[k].typed) begin
				while (pending_events.size() > base) void'(pending_events.pop_back());
				pending_events.push_back(directed_rows[k].want);
			end
		end

		// narrowest window, every run reported; a sweep fills all entries for a full flush
		settle();
		set_config(16'd1, 8'd1);
		t0 = clock_ms + 32'd1000;
		for (int c = 0; c < NCTRL; c++) begin
			it.cmd = mcta_pkg::CMD_RECORD;
			it.msg_kind = mcta_pkg::MSG_CONTROLLER;
			it.rec_channel = 5'(c % 16 + 1);
			it.first_byte = 7'(c);
			it.second_byte = 7'($urandom_range(0, 127));
			it.now_ms = t0;
			send_item(it, 0);
			aggregate_item(it);
		end
		it.cmd = mcta_pkg::CMD_FLUSH;
		it.now_ms = t0 + {16'd0, win_ms};
		clock_ms = it.now_ms;
		send_item(it, 0);
		aggregate_item(it);
		feed_random(100, 17);

		settle();
		set_config(16'd65535, 8'd2);
		feed_random(100, 56);

		settle();
		set_config(16'd40, 8'd3);
		feed_random(55, 0);
		settle();
		feed_random(55, 0);

		// widest window, highest minimum: a gap of the full window closes a short run unreported
		settle();
		set_config(16'd65535, 8'd255);
		t0 = clock_ms + 32'd70000;
		it.cmd = mcta_pkg::CMD_RECORD;
		it.msg_kind = mcta_pkg::MSG_CONTROLLER;
		it.rec_channel = 5'd9;
		it.first_byte = 7'd9;
		it.now_ms = t0;
		for (int n = 0; n < 3; n++) begin
			it.second_byte = 7'($urandom_range(0, 127));
			send_item(it, 0);
			aggregate_item(it);
		end
		it.now_ms = t0 + 32'd65535;
		clock_ms = it.now_ms;
		send_item(it, 0);
		aggregate_item(it);

		settle();
		if (n_fail == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/mcta_pkg.sv
design/mcta_ctrl.sv
design/mcta_datapath.sv
design/midi_controller_turn_aggregator_unit.sv
bench/tb.sv
